// File: hw/rtl/seven_segment_frame_builder_macros.svh
// Assertion macros used by the frame builder sequencer, ssfb_seq.
// Each use expands to one named concurrent assertion clocked on the rising edge.
// Depends on nothing.
`ifndef SEVEN_SEGMENT_FRAME_BUILDER_MACROS_SVH
`define SEVEN_SEGMENT_FRAME_BUILDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSFB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ssfb_pkg.sv
// Package for the seven-segment frame builder: types, bus command bytes,
// reciprocal constants, the glyph table and the symbol sequence function.
// Depends on nothing.
package ssfb_pkg;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_STOP  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } sym_t;

  // One display update, ready for the sequencer: mode and four digit bytes, units first.
  typedef struct packed {
    logic            mode;
    logic [3:0][7:0] codes;
  } frame_t;

  localparam logic [13:0] NUMBER_MAX     = 14'd9999;
  localparam logic [7:0]  CMD_AUTO_INC   = 8'h40;
  localparam logic [7:0]  CMD_FIXED_ADDR = 8'h40 + 8'h04;
  localparam logic [7:0]  CMD_ADDR_BASE  = 8'hC0;
  localparam logic [7:0]  CMD_DISPLAY_ON = 8'h80 + 8'h0f;
  localparam logic [7:0]  COLON_BIT      = 8'h80;
  localparam logic [7:0]  BLANK_CODE     = 8'h00;

  // Scaled reciprocals, exact for every value up to NUMBER_MAX.
  localparam logic [12:0] RECIP_10   = 13'd6554;  // shift 16
  localparam logic [12:0] RECIP_100  = 13'd5243;  // shift 19
  localparam logic [13:0] RECIP_1000 = 14'd8389;  // shift 23

  localparam logic [3:0] M0_LAST_STEP = 4'd12;
  localparam logic [3:0] M1_LAST_STEP = 4'd9;
  localparam logic [1:0] LAST_POS     = 2'd3;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    unique case (digit)
      4'd0:    code = 8'h3f;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5b;
      4'd3:    code = 8'h4f;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6d;
      4'd6:    code = 8'h7d;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7f;
      4'd9:    code = 8'h6f;
      default: code = BLANK_CODE;
    endcase
    return code;
  endfunction

  // Symbol at a given step of a run. Mode 0 is one 13-step run; mode 1 is
  // a 10-step run repeated for each digit position.
  function automatic sym_t ssfb_symbol(input logic mode, input logic [1:0] pos,
                                       input logic [3:0] step,
                                       input logic [3:0][7:0] codes);
    sym_t       s;
    logic [3:0] idx;
    idx    = step - 4'd5;
    s.kind = KIND_START;
    s.data = 8'h00;
    if (!mode) begin
      unique case (step)
        4'd0, 4'd3, 4'd10: s.kind = KIND_START;
        4'd2, 4'd9, 4'd12: s.kind = KIND_STOP;
        4'd1: begin
          s.kind = KIND_BYTE;
          s.data = CMD_AUTO_INC;
        end
        4'd4: begin
          s.kind = KIND_BYTE;
          s.data = CMD_ADDR_BASE;
        end
        4'd5, 4'd6, 4'd7, 4'd8: begin
          s.kind = KIND_BYTE;
          s.data = codes[idx[1:0]];
        end
        4'd11: begin
          s.kind = KIND_BYTE;
          s.data = CMD_DISPLAY_ON;
        end
        default: s.kind = KIND_START;
      endcase
    end else begin
      unique case (step)
        4'd0, 4'd3, 4'd7: s.kind = KIND_START;
        4'd2, 4'd6, 4'd9: s.kind = KIND_STOP;
        4'd1: begin
          s.kind = KIND_BYTE;
          s.data = CMD_FIXED_ADDR;
        end
        4'd4: begin
          s.kind = KIND_BYTE;
          s.data = CMD_ADDR_BASE | {6'b000000, pos};
        end
        4'd5: begin
          s.kind = KIND_BYTE;
          s.data = codes[pos];
        end
        4'd8: begin
          s.kind = KIND_BYTE;
          s.data = CMD_DISPLAY_ON;
        end
        default: s.kind = KIND_START;
      endcase
    end
    return s;
  endfunction

endpackage

// File: hw/rtl/ssfb_if.sv
// Valid/ready channel interfaces of the frame builder: the number request
// channel and the bus symbol channel. Depends on nothing.
interface ssfb_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [13:0] number;
  logic        colon;

  modport source(output valid, mode, number, colon, input ready);
  modport sink(input valid, mode, number, colon, output ready);
endinterface

interface ssfb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] symbol_kind;
  logic [7:0] data_byte;
  logic       last_of_run;

  modport source(output valid, symbol_kind, data_byte, last_of_run, input ready);
  modport sink(input valid, symbol_kind, data_byte, last_of_run, output ready);
endinterface

// File: hw/rtl/ssfb_digits.sv
// Number-to-glyph pipeline: saturate, split into decimal digits with
// reciprocal multiplies, map to segment codes. Uses ssfb_pkg and ssfb_in_if.
module ssfb_digits
  import ssfb_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  ssfb_in_if.sink       in_ch,
  output logic          frame_valid,
  input  logic          frame_ready,
  output frame_t        frame
);

  // Stage A: accepted request, number already saturated.
  logic        a_valid_r;
  logic        a_mode_r;
  logic        a_colon_r;
  logic [13:0] a_num_r;
  logic        a_ready;

  // Stage B: quotients by 10, 100 and 1000.
  logic        b_valid_r;
  logic        b_mode_r;
  logic        b_colon_r;
  logic [13:0] b_num_r;
  logic [9:0]  b_q1_r;
  logic [6:0]  b_q2_r;
  logic [3:0]  b_q3_r;
  logic        b_ready;

  logic        f_valid_r;
  frame_t      f_r;
  frame_t      f_nxt;
  logic        f_ready;

  logic [26:0] prod1;
  logic [26:0] prod2;
  logic [26:0] prod3;
  logic [13:0] units;
  logic [9:0]  tens;
  logic [6:0]  hundreds;
  logic [3:0][3:0] digit;
  logic [3:0]  shown;
  logic [7:0]  code;

  assign f_ready     = !f_valid_r || frame_ready;
  assign b_ready     = !b_valid_r || f_ready;
  assign a_ready     = !a_valid_r || b_ready;
  assign in_ch.ready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_ch.valid) begin
      a_mode_r  <= in_ch.mode;
      a_colon_r <= in_ch.colon;
      a_num_r   <= (in_ch.number > NUMBER_MAX) ? NUMBER_MAX : in_ch.number;
    end
  end

  assign prod1 = 27'(a_num_r) * 27'(RECIP_10);
  assign prod2 = 27'(a_num_r) * 27'(RECIP_100);
  assign prod3 = 27'(a_num_r) * 27'(RECIP_1000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid_r) begin
      b_mode_r  <= a_mode_r;
      b_colon_r <= a_colon_r;
      b_num_r   <= a_num_r;
      b_q1_r    <= prod1[25:16];
      b_q2_r    <= prod2[25:19];
      b_q3_r    <= prod3[26:23];
    end
  end

  // Remainders: each digit is a quotient minus ten times the next quotient.
  assign units    = b_num_r - (14'({b_q1_r, 3'b000}) + 14'({b_q1_r, 1'b0}));
  assign tens     = b_q1_r - (10'({b_q2_r, 3'b000}) + 10'({b_q2_r, 1'b0}));
  assign hundreds = b_q2_r - (7'({b_q3_r, 3'b000}) + 7'({b_q3_r, 1'b0}));

  assign digit[0] = units[3:0];
  assign digit[1] = tens[3:0];
  assign digit[2] = hundreds[3:0];
  assign digit[3] = b_q3_r;

  // A position is significant when the number reaches its power of ten.
  assign shown[0] = (b_num_r != 14'd0);
  assign shown[1] = (b_q1_r != 10'd0);
  assign shown[2] = (b_q2_r != 7'd0);
  assign shown[3] = (b_q3_r != 4'd0);

  always_comb begin
    f_nxt      = '0;
    f_nxt.mode = b_mode_r;
    code       = 8'h00;
    for (int i = 0; i < 4; i++) begin
      code = seg_code(digit[i]);
      if (b_mode_r) begin
        f_nxt.codes[i] = shown[i] ? code : BLANK_CODE;
      end else if (i == 2 && b_colon_r) begin
        f_nxt.codes[i] = code | COLON_BIT;
      end else begin
        f_nxt.codes[i] = code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (f_ready) begin
      f_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f_ready && b_valid_r) begin
      f_r <= f_nxt;
    end
  end

  assign frame_valid = f_valid_r;
  assign frame       = f_r;

endmodule

// File: hw/rtl/ssfb_seq.sv
// Symbol sequencer: walks one frame's bus run into the output register, one
// symbol per cycle while out_ch is ready. Uses ssfb_pkg, ssfb_out_if, the macro header.
`include "seven_segment_frame_builder_macros.svh"

module ssfb_seq
  import ssfb_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          frame_valid,
  output logic          frame_ready,
  input  frame_t        frame,
  ssfb_out_if.source    out_ch
);

  logic            busy_r;
  logic            mode_r;
  logic [3:0][7:0] codes_r;
  logic [1:0]      pos_r;
  logic [3:0]      step_r;

  logic            out_valid_r;
  logic [1:0]      out_kind_r;
  logic [7:0]      out_byte_r;
  logic            out_last_r;

  logic            out_space;
  logic            emit;
  logic            step_end;
  logic            sym_last;
  logic            frame_take;
  sym_t            sym;

  assign out_space  = !out_valid_r || out_ch.ready;
  assign emit       = busy_r && out_space;
  assign step_end   = mode_r ? (step_r == M1_LAST_STEP) : (step_r == M0_LAST_STEP);
  assign sym_last   = step_end && (!mode_r || pos_r == LAST_POS);
  assign frame_ready = !busy_r || (emit && sym_last);
  assign frame_take = frame_valid && frame_ready;
  assign sym        = ssfb_symbol(mode_r, pos_r, step_r, codes_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= 2'd0;
      step_r <= 4'd0;
    end else if (frame_take) begin
      busy_r <= 1'b1;
      pos_r  <= 2'd0;
      step_r <= 4'd0;
    end else if (emit) begin
      if (sym_last) begin
        busy_r <= 1'b0;
      end else if (step_end) begin
        pos_r  <= pos_r + 2'd1;
        step_r <= 4'd0;
      end else begin
        step_r <= step_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      mode_r  <= frame.mode;
      codes_r <= frame.codes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= sym.kind;
      out_byte_r <= sym.data;
      out_last_r <= sym_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.symbol_kind = out_kind_r;
  assign out_ch.data_byte   = out_byte_r;
  assign out_ch.last_of_run = out_last_r;

  `SSFB_ASSERT_IMP(a_last_is_stop, clk, rst_n, out_valid_r && out_last_r, out_kind_r == KIND_STOP, "run ends on a symbol other than stop")
  `SSFB_ASSERT_IMP(a_step_bound, clk, rst_n, busy_r && mode_r, step_r <= M1_LAST_STEP, "per-digit run step out of range")
  `SSFB_ASSERT_NEXT(a_frame_started, clk, rst_n, frame_take, busy_r && step_r == 4'd0 && pos_r == 2'd0, "accepted frame did not start a run")
  `SSFB_ASSERT_NEXT(a_run_closed, clk, rst_n, emit && sym_last && !frame_valid, !busy_r, "sequencer stayed busy after the last symbol")

endmodule

// File: hw/rtl/seven_segment_frame_builder.sv
// Each request on in_ch (mode, number, colon) produces one run of bus symbols on
// out_ch: 13 symbols in mode 0 (auto-increment frame, colon if requested) and 40
// in mode 1 (one fixed-address frame per digit, leading zeros blank). Numbers
// above 9999 show as 9999. The output register delivers one symbol per cycle
// while out_ch is ready; the next request, if already decoded, is started in the
// cycle after the previous run's last symbol, with no gap. After its request is
// accepted, the first symbol of a run passes the input, quotient and glyph
// registers and then the sequencer's output register.
// The block holds no state that needs initializing beyond reset.
module seven_segment_frame_builder
  import ssfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ssfb_in_if.sink    in_ch,
  ssfb_out_if.source out_ch
);

  logic   frame_valid;
  logic   frame_ready;
  frame_t frame;

  ssfb_digits u_digits (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  ssfb_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .out_ch      (out_ch)
  );

endmodule

// File: verif/seven_segment_frame_builder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for seven_segment_frame_builder: number requests in, bus symbols out.
// Depends on ssfb_pkg, the ssfb_in_if / ssfb_out_if interfaces and the block itself.
module seven_segment_frame_builder_tb;
  import ssfb_pkg::*;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } bus_symbol_t;

  typedef struct {
    logic            mode;
    logic [13:0]     number;
    logic            colon;
    bit              typed;
    logic [3:0][7:0] codes;
  } request_row_t;

  // Glyphs for 0..9, index 0 in the low byte.
  localparam logic [9:0][7:0] GLYPHS = {8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d,
                                        8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f};
  localparam int RANDOM_PER_PHASE = 40;

  // Rows marked typed carry the digit bytes, units first, written out by hand.
  request_row_t directed_rows [22] = '{
    '{1'b0, 14'd0,     1'b0, 1'b1, 32'h3f3f3f3f},
    '{1'b1, 14'd0,     1'b0, 1'b1, 32'h00000000},
    '{1'b0, 14'd9999,  1'b1, 1'b1, 32'h6fef6f6f},
    '{1'b1, 14'd9999,  1'b1, 1'b1, 32'h6f6f6f6f},
    '{1'b0, 14'd16383, 1'b0, 1'b1, 32'h6f6f6f6f},
    '{1'b0, 14'd10000, 1'b1, 1'b1, 32'h6fef6f6f},
    '{1'b1, 14'd10000, 1'b0, 1'b1, 32'h6f6f6f6f},
    '{1'b1, 14'd16383, 1'b1, 1'b1, 32'h6f6f6f6f},
    '{1'b1, 14'd1,     1'b0, 1'b0, 32'h0},
    '{1'b1, 14'd9,     1'b1, 1'b0, 32'h0},
    '{1'b1, 14'd10,    1'b0, 1'b0, 32'h0},
    '{1'b1, 14'd99,    1'b0, 1'b0, 32'h0},
    '{1'b1, 14'd100,   1'b0, 1'b0, 32'h0},
    '{1'b1, 14'd999,   1'b1, 1'b0, 32'h0},
    '{1'b1, 14'd1000,  1'b0, 1'b0, 32'h0},
    '{1'b0, 14'd1234,  1'b1, 1'b0, 32'h0},
    '{1'b0, 14'd5678,  1'b0, 1'b0, 32'h0},
    '{1'b0, 14'd8080,  1'b1, 1'b0, 32'h0},
    '{1'b0, 14'd7,     1'b1, 1'b0, 32'h0},
    '{1'b1, 14'd8192,  1'b0, 1'b0, 32'h0},
    '{1'b0, 14'd4096,  1'b1, 1'b0, 32'h0},
    '{1'b1, 14'd2048,  1'b0, 1'b0, 32'h0}
  };

  logic clk = 1'b0;
  logic rst_n;

  ssfb_in_if  in_ch ();
  ssfb_out_if out_ch ();

  seven_segment_frame_builder dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bus_symbol_t     pending_symbols [$];
  logic            typed_valid;
  logic [3:0][7:0] typed_codes;
  int              sender_idle_pct;
  int              receiver_stall_pct;
  int              mismatch_count;
  int              symbols_checked;
  int              requests_per_mode [2];
  int              saturated_requests;

  // Digit bytes the display should receive for one request, units first.
  function automatic logic [3:0][7:0] glyph_codes(input logic mode, input logic [13:0] number,
                                                  input logic colon);
    int unsigned     value;
    int unsigned     rest;
    int unsigned     significant;
    logic [3:0][7:0] codes;
    value       = (number > NUMBER_MAX) ? NUMBER_MAX : number;
    significant = 0;
    rest        = value;
    while (rest != 0) begin
      significant++;
      rest /= 10;
    end
    rest = value;
    for (int i = 0; i < 4; i++) begin
      codes[i] = GLYPHS[rest % 10];
      if (mode) begin
        if (i >= significant) codes[i] = BLANK_CODE;
      end else if (i == 2 && colon) begin
        codes[i] = codes[i] | COLON_BIT;
      end
      rest /= 10;
    end
    return codes;
  endfunction

  task automatic push_symbol(input kind_t kind, input logic [7:0] data);
    bus_symbol_t s;
    s.kind = kind;
    s.data = data;
    s.last = 1'b0;
    pending_symbols.push_back(s);
  endtask

  task automatic push_command(input logic [7:0] data);
    push_symbol(KIND_START, 8'h00);
    push_symbol(KIND_BYTE, data);
    push_symbol(KIND_STOP, 8'h00);
  endtask

  task automatic push_symbol_run(input logic mode, input logic [3:0][7:0] codes);
    bus_symbol_t s;
    if (!mode) begin
      push_command(CMD_AUTO_INC);
      push_symbol(KIND_START, 8'h00);
      push_symbol(KIND_BYTE, CMD_ADDR_BASE);
      for (int i = 0; i < 4; i++) push_symbol(KIND_BYTE, codes[i]);
      push_symbol(KIND_STOP, 8'h00);
      push_command(CMD_DISPLAY_ON);
    end else begin
      for (int i = 0; i < 4; i++) begin
        push_command(CMD_FIXED_ADDR);
        push_symbol(KIND_START, 8'h00);
        push_symbol(KIND_BYTE, CMD_ADDR_BASE + 8'(i));
        push_symbol(KIND_BYTE, codes[i]);
        push_symbol(KIND_STOP, 8'h00);
        push_command(CMD_DISPLAY_ON);
      end
    end
    s      = pending_symbols.pop_back();
    s.last = 1'b1;
    pending_symbols.push_back(s);
  endtask

  task automatic check_symbol();
    bus_symbol_t want;
    if (pending_symbols.size() == 0) begin
      mismatch_count++;
      $display("%0t: expected no symbol, actual kind=%0d data=%h last=%b", $time,
               out_ch.symbol_kind, out_ch.data_byte, out_ch.last_of_run);
      return;
    end
    want = pending_symbols.pop_front();
    symbols_checked++;
    if (out_ch.symbol_kind !== want.kind) begin
      mismatch_count++;
      $display("%0t: symbol_kind expected %0d actual %0d", $time, want.kind,
               out_ch.symbol_kind);
    end
    if (out_ch.data_byte !== want.data) begin
      mismatch_count++;
      $display("%0t: data_byte expected %h actual %h", $time, want.data, out_ch.data_byte);
    end
    if (out_ch.last_of_run !== want.last) begin
      mismatch_count++;
      $display("%0t: last_of_run expected %b actual %b", $time, want.last,
               out_ch.last_of_run);
    end
  endtask

  // Accepted requests are turned into expected symbols; accepted symbols are checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        requests_per_mode[in_ch.mode]++;
        if (in_ch.number > NUMBER_MAX) saturated_requests++;
        push_symbol_run(in_ch.mode, typed_valid ? typed_codes :
                        glyph_codes(in_ch.mode, in_ch.number, in_ch.colon));
      end
      if (out_ch.valid && out_ch.ready) check_symbol();
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic send_request(input logic mode, input logic [13:0] number, input logic colon,
                              input bit typed, input logic [3:0][7:0] codes);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= mode;
    in_ch.number <= number;
    in_ch.colon  <= colon;
    typed_valid  <= typed;
    typed_codes  <= codes;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  initial begin
    logic [13:0] number;
    int          digits;
    in_ch.valid        = 1'b0;
    in_ch.mode         = 1'b0;
    in_ch.number       = '0;
    in_ch.colon        = 1'b0;
    typed_valid        = 1'b0;
    typed_codes        = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    mismatch_count     = 0;
    symbols_checked    = 0;
    requests_per_mode  = '{0, 0};
    saturated_requests = 0;
    rst_n              = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].mode, directed_rows[i].number, directed_rows[i].colon,
                   directed_rows[i].typed, directed_rows[i].codes);

    // Phases: no idling, slow sender, slow receiver, both somewhat slow.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    <= 0;
          receiver_stall_pct <= 0;
        end
        1: begin
          sender_idle_pct    <= 88;
          receiver_stall_pct <= 0;
        end
        2: begin
          sender_idle_pct    <= 0;
          receiver_stall_pct <= 88;
        end
        default: begin
          sender_idle_pct    <= 23;
          receiver_stall_pct <= 23;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        case ($urandom_range(9))
          0: number = 14'($urandom_range(16383, 10000));
          1: number = 14'($urandom_range(16383));
          default: begin
            // Pick a digit count first so leading blanks show up evenly.
            digits = $urandom_range(4);
            if (digits == 0) number = '0;
            else number = 14'($urandom_range(10 ** digits - 1, 10 ** (digits - 1)));
          end
        endcase
        send_request(1'($urandom_range(1)), number, 1'($urandom_range(1)), 1'b0, '0);
      end
    end
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (pending_symbols.size() != 0);
    repeat (40) @(posedge clk);

    $display("Covered %0d mode 0 and %0d mode 1 requests (%0d saturated), %0d symbols checked.",
             requests_per_mode[0], requests_per_mode[1], saturated_requests, symbols_checked);
    $display("Idle phases: none, sender 88%%, receiver 88%%, both 23%%.");
    if (mismatch_count == 0) begin
      $display("seven_segment_frame_builder_tb OK");
    end else begin
      $display("seven_segment_frame_builder_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d symbols still expected.", pending_symbols.size());
    $display("seven_segment_frame_builder_tb NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ssfb_pkg.sv
hw/rtl/ssfb_if.sv
hw/rtl/ssfb_digits.sv
hw/rtl/ssfb_seq.sv
hw/rtl/seven_segment_frame_builder.sv
verif/seven_segment_frame_builder_tb.sv
